>>> hdl/ctc_pkg.sv
// Shared types and constants for the C-subset token classifier.
// Result record, token kinds, scan modes and result queue sizing.
// No dependencies.
package ctc_pkg;

   localparam int MAX_TOKEN_LEN = 255;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      KIND_IDENT     = 3'd0,
      KIND_KEYWORD   = 3'd1,
      KIND_NUMBER    = 3'd2,
      KIND_OPERATOR  = 3'd3,
      KIND_SEPARATOR = 3'd4,
      KIND_INVALID   = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start;
      logic [7:0]  length;
      logic [7:0]  char_code;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

>>> hdl/ctc_req_if.sv
// Input channel of the token classifier: one text byte per transfer.
// Depends on nothing.
interface ctc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

>>> hdl/ctc_rsp_if.sv
// Result channel of the token classifier: one token record per transfer.
// Depends on nothing.
interface ctc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [31:0] token_start;
   logic [7:0]  token_length;
   logic [7:0]  token_char;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output token_char, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input token_char, input last_of_run,
                   output ready);
endinterface

>>> hdl/ctc_scanner.sv
// Input register, scan state and per-byte token logic.
// Produces zero, one or two token records per byte for the result queue.
// Depends on ctc_pkg and ctc_req_if.
module ctc_scanner
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ctc_req_if.sink     req,
   input  logic        space_ok,
   output push_type    push
);

   localparam int KW_COUNT  = 6;
   localparam int KW_MAXLEN = 5;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
      '{"i", "n", "t", 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t"},
      '{"i", "f", 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e"}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd5};

   function automatic logic [KW_COUNT-1:0] advance_candidates(
      input logic [KW_COUNT-1:0] mask,
      input logic [7:0]          idx,
      input logic [7:0]          b
   );
      logic [KW_COUNT-1:0] nxt;
      nxt = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (mask[k] && (idx < {5'd0, KW_LEN[k]}) && (KW_TEXT[k][idx[2:0]] == b)) begin
            nxt[k] = 1'b1;
         end
      end
      return nxt;
   endfunction

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   mode_type            mode_ff, mode_in;
   logic [31:0]         start_ff, start_in;
   logic [7:0]          len_ff, len_in;
   logic [KW_COUNT-1:0] cand_ff, cand_in;
   logic [31:0]         pos_ff, pos_in;

   logic       fire;
   logic       is_letter, is_digit, is_op, is_sep, is_blank;
   logic       pend_ident, pend_number, kw_hit;
   logic       flush_v, own_v;
   kind_type   own_kind;
   logic [7:0] len_inc;
   result_type flush_res, own_res;

   assign fire      = in_valid_ff && space_ok;
   assign req.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         in_byte_in  = req.text_byte;
      end
   end

   always_comb begin
      is_letter = ((in_byte_ff >= "a") && (in_byte_ff <= "z")) ||
                  ((in_byte_ff >= "A") && (in_byte_ff <= "Z")) || (in_byte_ff == "_");
      is_digit  = (in_byte_ff >= "0") && (in_byte_ff <= "9");
      is_op     = (in_byte_ff == "+") || (in_byte_ff == "-") ||
                  (in_byte_ff == "*") || (in_byte_ff == "/");
      is_sep    = (in_byte_ff == ";") || (in_byte_ff == "(") || (in_byte_ff == ")") ||
                  (in_byte_ff == "{") || (in_byte_ff == "}");
      is_blank  = (in_byte_ff == 8'd32) || (in_byte_ff == 8'd10);

      pend_ident  = (mode_ff == MODE_IDENT);
      pend_number = (mode_ff == MODE_NUMBER);

      kw_hit = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (cand_ff[k] && (len_ff == {5'd0, KW_LEN[k]})) begin
            kw_hit = 1'b1;
         end
      end

      len_inc = (len_ff < 8'(MAX_TOKEN_LEN)) ? len_ff + 8'd1 : len_ff;

      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      cand_in  = cand_ff;
      pos_in   = pos_ff;
      flush_v  = 1'b0;
      own_v    = 1'b0;
      own_kind = KIND_INVALID;

      if (fire) begin
         if (in_byte_ff == 8'd0) begin
            flush_v  = pend_ident || pend_number;
            mode_in  = MODE_IDLE;
            len_in   = 8'd0;
            cand_in  = '0;
            start_in = 32'd0;
            pos_in   = 32'd0;
         end else begin
            pos_in = pos_ff + 32'd1;
            if (pend_ident && (is_letter || is_digit)) begin
               cand_in = advance_candidates(cand_ff, len_ff, in_byte_ff);
               len_in  = len_inc;
            end else if (pend_number && is_digit) begin
               len_in = len_inc;
            end else begin
               flush_v = pend_ident || pend_number;
               mode_in = MODE_IDLE;
               len_in  = 8'd0;
               cand_in = '0;
               if (is_letter) begin
                  mode_in  = MODE_IDENT;
                  start_in = pos_ff;
                  len_in   = 8'd1;
                  cand_in  = advance_candidates('1, 8'd0, in_byte_ff);
               end else if (is_digit) begin
                  mode_in  = MODE_NUMBER;
                  start_in = pos_ff;
                  len_in   = 8'd1;
               end else if (is_op) begin
                  own_v    = 1'b1;
                  own_kind = KIND_OPERATOR;
               end else if (is_sep) begin
                  own_v    = 1'b1;
                  own_kind = KIND_SEPARATOR;
               end else if (!is_blank) begin
                  own_v    = 1'b1;
                  own_kind = KIND_INVALID;
               end
            end
         end
      end

      flush_res.kind      = pend_ident ? (kw_hit ? KIND_KEYWORD : KIND_IDENT) : KIND_NUMBER;
      flush_res.start     = start_ff;
      flush_res.length    = len_ff;
      flush_res.char_code = 8'd0;
      flush_res.last      = !own_v;

      own_res.kind      = own_kind;
      own_res.start     = pos_ff;
      own_res.length    = 8'd1;
      own_res.char_code = in_byte_ff;
      own_res.last      = 1'b1;

      push.count  = {1'b0, flush_v} + {1'b0, own_v};
      push.first  = flush_v ? flush_res : own_res;
      push.second = own_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         start_ff    <= 32'd0;
         len_ff      <= 8'd0;
         cand_ff     <= '0;
         pos_ff      <= 32'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         start_ff    <= start_in;
         len_ff      <= len_in;
         cand_ff     <= cand_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

endmodule

>>> hdl/ctc_result_queue.sv
// Small result queue: takes up to two token records a cycle, hands out one.
// Depends on ctc_pkg and ctc_rsp_if.
module ctc_result_queue
   import ctc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space_ok,
   ctc_rsp_if.source rsp
);

   result_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  pop;
   result_type            head;

   assign pop      = rsp.valid && rsp.ready;
   assign space_ok = (count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
      count_in  = count_ff + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QUEUE_AW'(1)] <= push.second;
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign rsp.valid        = (count_ff != '0);
   assign rsp.token_kind   = head.kind;
   assign rsp.token_start  = head.start;
   assign rsp.token_length = head.length;
   assign rsp.token_char   = head.char_code;
   assign rsp.last_of_run  = head.last;

endmodule

>>> hdl/c_subset_token_classifier.sv
// Top level of the C-subset token classifier.
// Depends on ctc_pkg, ctc_req_if, ctc_rsp_if, ctc_scanner, ctc_result_queue.
//
// Usage:
//   req_chan carries one text byte per transfer; byte 0 ends the text, flushes
//   a pending identifier, keyword or number and restarts the byte offset at 0.
//   rsp_chan carries one token record per transfer: kind, start offset,
//   length (saturating at 255), the character for one-character tokens, and
//   last_of_run on the final record caused by a given byte.
//   A byte is taken every cycle while the result queue has room for two
//   records. A record passes the input register and the result queue
//   before rsp_chan; a byte that ends a token and is a token itself gives
//   two records, taken together and handed out one at a time. With at most
//   one record per byte on average and no receiver stall the block sustains
//   one byte per cycle; the single-record-a-cycle output port is the limit.
//   Reset clears the scan state, the byte offset and the queue.
//   When the receiver stalls the queue fills (up to four records); once it
//   holds three or more, a waiting byte stays in the input register and
//   req_chan ready drops until records drain; nothing is lost.
module c_subset_token_classifier
   import ctc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ctc_req_if.sink   req_chan,
   ctc_rsp_if.source rsp_chan
);

   push_type push;
   logic     space_ok;

   ctc_scanner u_scanner (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .space_ok (space_ok),
      .push     (push)
   );

   ctc_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_chan)
   );

endmodule

>>> hdl/ctc_checker.sv
// Port-level checks for the C-subset token classifier, bound to the top.
// Depends on ctc_pkg and c_subset_token_classifier.
module ctc_checker
   import ctc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  token_kind,
   input logic [31:0] token_start,
   input logic [7:0]  token_length,
   input logic [7:0]  token_char,
   input logic        last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(token_kind) && $stable(token_start) &&
         $stable(token_length) && $stable(token_char) && $stable(last_of_run))
      else $error("result changed while stalled");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> token_length != 8'd0)
      else $error("zero token length");

   a_single_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == KIND_OPERATOR || token_kind == KIND_SEPARATOR ||
         token_kind == KIND_INVALID) |-> token_length == 8'd1 && token_char != 8'd0)
      else $error("bad one-character token");

   a_multi_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == KIND_IDENT || token_kind == KIND_KEYWORD ||
         token_kind == KIND_NUMBER) |-> token_char == 8'd0)
      else $error("character set on multi-character token");

endmodule

bind c_subset_token_classifier ctc_checker u_ctc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .token_kind   (rsp_chan.token_kind),
   .token_start  (rsp_chan.token_start),
   .token_length (rsp_chan.token_length),
   .token_char   (rsp_chan.token_char),
   .last_of_run  (rsp_chan.last_of_run)
);

>>> test/ctc_token_checker.sv
// Token checker for the C-subset token classifier: watches both channels,
// predicts the token records of every accepted byte and compares them in order.
// Depends on ctc_pkg.
`timescale 1ns / 100ps
module ctc_token_checker
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_token_kind,
   input  logic [31:0] rsp_token_start,
   input  logic [7:0]  rsp_token_length,
   input  logic [7:0]  rsp_token_char,
   input  logic        rsp_last_of_run,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   mode_type    scan_state;
   logic [31:0] tok_start;
   logic [7:0]  tok_len;
   logic [5:0]  kw_hits;
   logic [31:0] next_pos;
   result_type  expected_tokens[$];
   result_type  step_tokens[2];
   int          step_count;

   function automatic string keyword_word(input int k);
      case (k)
         0: return "int";
         1: return "float";
         2: return "if";
         3: return "else";
         4: return "for";
         default: return "while";
      endcase
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // keep keywords whose character at idx matches ch
   function automatic logic [5:0] narrow_keywords(input logic [5:0] mask,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] ch);
      string      word;
      logic [5:0] hits;
      hits = '0;
      for (int k = 0; k < 6; k++) begin
         word = keyword_word(k);
         if (mask[k] && int'(idx) < word.len() && word[int'(idx)] == ch)
            hits[k] = 1'b1;
      end
      return hits;
   endfunction

   task automatic emit_token(input kind_type kind, input logic [31:0] start,
                             input logic [7:0] length, input logic [7:0] ch);
      result_type tok;
      tok.kind      = kind;
      tok.start     = start;
      tok.length    = length;
      tok.char_code = ch;
      tok.last      = 1'b0;
      step_tokens[step_count] = tok;
      step_count++;
   endtask

   task automatic flush_pending();
      kind_type kind;
      string    word;
      if (scan_state == MODE_IDENT) begin
         kind = KIND_IDENT;
         for (int k = 0; k < 6; k++) begin
            word = keyword_word(k);
            if (kw_hits[k] && int'(tok_len) == word.len())
               kind = KIND_KEYWORD;
         end
         emit_token(kind, tok_start, tok_len, 8'h00);
      end else if (scan_state == MODE_NUMBER) begin
         emit_token(KIND_NUMBER, tok_start, tok_len, 8'h00);
      end
      scan_state = MODE_IDLE;
      tok_len    = '0;
      kw_hits    = '0;
   endtask

   task automatic scan_byte(input logic [7:0] b);
      logic [31:0] pos;
      result_type  tail;
      pos        = next_pos;
      step_count = 0;
      if (b == 8'h00) begin
         flush_pending();
         tok_start = '0;
         next_pos  = '0;
      end else begin
         if (scan_state == MODE_IDENT && (is_letter(b) || is_digit(b))) begin
            kw_hits = narrow_keywords(kw_hits, tok_len, b);
            if (tok_len < MAX_TOKEN_LEN) tok_len++;
         end else if (scan_state == MODE_NUMBER && is_digit(b)) begin
            if (tok_len < MAX_TOKEN_LEN) tok_len++;
         end else begin
            flush_pending();
            if (is_letter(b)) begin
               scan_state = MODE_IDENT;
               tok_start  = pos;
               tok_len    = 8'd1;
               kw_hits    = narrow_keywords(6'h3f, 8'd0, b);
            end else if (is_digit(b)) begin
               scan_state = MODE_NUMBER;
               tok_start  = pos;
               tok_len    = 8'd1;
            end else if (b == "+" || b == "-" || b == "*" || b == "/") begin
               emit_token(KIND_OPERATOR, pos, 8'd1, b);
            end else if (b == ";" || b == "(" || b == ")" || b == "{" || b == "}") begin
               emit_token(KIND_SEPARATOR, pos, 8'd1, b);
            end else if (b != " " && b != "\n") begin
               emit_token(KIND_INVALID, pos, 8'd1, b);
            end
         end
         next_pos = pos + 32'd1;
      end
      if (step_count > 0) begin
         tail      = step_tokens[step_count - 1];
         tail.last = 1'b1;
         step_tokens[step_count - 1] = tail;
      end
      for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_tokens[i]);
   endtask

   always @(posedge clock) begin : check_tokens
      result_type want;
      if (reset) begin
         scan_state = MODE_IDLE;
         tok_start  = '0;
         tok_len    = '0;
         kw_hits    = '0;
         next_pos   = '0;
         fail_count = 0;
         expected_tokens.delete();
      end else begin
         if (req_valid && req_ready) scan_byte(req_text_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t unexpected token: expected none, got kind %0d start %0d len %0d char %02h last %0b",
                        $time, rsp_token_kind, rsp_token_start, rsp_token_length,
                        rsp_token_char, rsp_last_of_run);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.kind || rsp_token_start !== want.start ||
                   rsp_token_length !== want.length || rsp_token_char !== want.char_code ||
                   rsp_last_of_run !== want.last) begin
                  $display("%0t token mismatch: expected kind %0d start %0d len %0d char %02h last %0b, got kind %0d start %0d len %0d char %02h last %0b",
                           $time, want.kind, want.start, want.length, want.char_code,
                           want.last, rsp_token_kind, rsp_token_start, rsp_token_length,
                           rsp_token_char, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_tokens.size();
   end

endmodule

>>> test/c_subset_token_classifier_tb.sv
// Testbench top for the C-subset token classifier: clock, reset, byte stimulus,
// receiver stalls, watchdog and verdict. Depends on ctc_pkg, ctc_req_if,
// ctc_rsp_if, c_subset_token_classifier and ctc_token_checker.
`timescale 1ns / 100ps
module c_subset_token_classifier_tb;
   import ctc_pkg::*;

   localparam int ITEM_TARGET    = 1450;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_TOKENS   = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned bytes_sent  = 0;
   int unsigned idle_cycles = 0;
   bit          tx_steady    = 1'b0;
   bit          rx_steady    = 1'b0;
   bit          hold_request = 1'b0;
   string       ident_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string       op_chars     = "+-*/";
   string       sep_chars    = ";(){}";

   ctc_req_if req_chan();
   ctc_rsp_if rsp_chan();

   c_subset_token_classifier i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ctc_token_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_text_byte    (req_chan.text_byte),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_token_kind   (rsp_chan.token_kind),
      .rsp_token_start  (rsp_chan.token_start),
      .rsp_token_length (rsp_chan.token_length),
      .rsp_token_char   (rsp_chan.token_char),
      .rsp_last_of_run  (rsp_chan.last_of_run),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver: random stalls per record, one long hold-off on request
   initial begin : receiver
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         stall = rx_steady ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      gap = tx_steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.text_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_chars(input string text, input int count);
      for (int i = 0; i < count; i++) send_byte(text[i]);
   endtask

   task automatic drain_tokens();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic string pick_keyword();
      case ($urandom_range(0, 5))
         0: return "int";
         1: return "float";
         2: return "if";
         3: return "else";
         4: return "for";
         default: return "while";
      endcase
   endfunction

   task automatic send_random_token();
      string word;
      case ($urandom_range(0, 11))
         0, 1: begin
            word = pick_keyword();
            send_chars(word, word.len());
         end
         2: begin
            // keyword prefix, optionally extended
            word = pick_keyword();
            send_chars(word, $urandom_range(1, word.len()));
            repeat ($urandom_range(0, 2)) send_byte(ident_chars[$urandom_range(0, 62)]);
         end
         3, 4: begin
            send_byte(ident_chars[$urandom_range(0, 52)]);
            repeat ($urandom_range(0, 7)) send_byte(ident_chars[$urandom_range(0, 62)]);
         end
         5: repeat ($urandom_range(1, 6)) send_byte(ident_chars[$urandom_range(53, 62)]);
         6: send_byte(op_chars[$urandom_range(0, 3)]);
         7: send_byte(sep_chars[$urandom_range(0, 4)]);
         8, 10: send_byte(8'($urandom_range(0, 255)));
         9: send_byte(8'h00);
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0, 1: send_byte(" ");
         2: send_byte("\n");
         3: send_byte(sep_chars[$urandom_range(0, 4)]);
         default: ;
      endcase
   endtask

   initial begin : stimulus
      int phase;
      req_chan.valid     = 1'b0;
      req_chan.text_byte = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // keyword, number then identifier, operators, separators, blanks,
      // invalid control and high bytes, flush of a pending token, empty end
      send_chars("int 9a_Z+-*/;(){}\t", 18);
      send_byte(8'h0D);
      send_byte(8'h0A);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte("x");
      send_byte(8'h00);
      send_byte(8'h00);
      drain_tokens();

      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            tx_steady    = 1'b1;
            hold_request = 1'b1;
         end
         if (phase == 3) begin
            tx_steady = 1'b1;
            rx_steady = 1'b1;
         end
         if (phase == 1) begin
            // long identifier starting like a keyword: saturates, never a keyword
            send_chars("while", 5);
            repeat (252) send_byte(ident_chars[$urandom_range(0, 62)]);
            send_byte(" ");
         end
         if (phase == 5) begin
            repeat (255) send_byte(ident_chars[$urandom_range(53, 62)]);
            send_byte(ident_chars[$urandom_range(0, 52)]);
         end
         repeat (PHASE_TOKENS) send_random_token();
         if ($urandom_range(0, 2) == 0) drain_tokens();
         phase++;
      end

      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> c_subset_token_classifier.f
hdl/ctc_pkg.sv
hdl/ctc_req_if.sv
hdl/ctc_rsp_if.sv
hdl/ctc_scanner.sv
hdl/ctc_result_queue.sv
hdl/c_subset_token_classifier.sv
hdl/ctc_checker.sv
test/ctc_token_checker.sv
test/c_subset_token_classifier_tb.sv
